// ===== sv/scpi_pkg.sv =====
// Shared types, character codes and handshake structs of the SCPI line parser.
package scpi_pkg;

	typedef logic [1:0] action_t;
	typedef logic [1:0] status_t;
	typedef logic signed [5:0] reply_len_t;

	localparam action_t ACT_PARSE   = 2'd0;
	localparam action_t ACT_EXEC    = 2'd1;
	localparam action_t ACT_DISCARD = 2'd2;

	localparam status_t STAT_IDLE  = 2'd0;
	localparam status_t STAT_READY = 2'd1;
	localparam status_t STAT_ERROR = 2'd2;

	localparam reply_len_t LEN_ZERO      = 6'sd0;
	localparam reply_len_t LEN_NOT_READY = -6'sd1;
	localparam reply_len_t LEN_IDN       = 6'sd17;

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_QUERY = 8'h3F;

	// Length of the identify command and the width of its character index.
	localparam int IDN_CHARS = 5;
	localparam int IDN_IDX_W = 3;
	typedef logic [IDN_IDX_W-1:0] idn_idx_t;

	typedef struct packed {
		logic take;
		logic exec_run;
		logic push;
	} ctrl_cmd_t;

	typedef struct packed {
		logic exec_req;
		logic cmp_done;
	} dp_stat_t;

	function automatic logic [7:0] idn_char(idn_idx_t i);
		logic [7:0] c;
		case (i)
			3'd0: c = CH_STAR;
			3'd1: c = 8'h49;
			3'd2: c = 8'h44;
			3'd3: c = 8'h4E;
			3'd4: c = CH_QUERY;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

// ===== sv/scpi_if.sv =====
// Valid/ready channel interfaces for requests and results of the SCPI parser.
interface scpi_req_if;
	logic                 valid;
	logic                 ready;
	scpi_pkg::action_t    action;
	logic [7:0]           rx_byte;

	modport source(output valid, output action, output rx_byte, input ready);
	modport sink(input valid, input action, input rx_byte, output ready);
endinterface

interface scpi_rsp_if;
	logic                 valid;
	logic                 ready;
	scpi_pkg::status_t    status;
	scpi_pkg::reply_len_t reply_len;
	logic                 query_seen;

	modport source(output valid, output status, output reply_len, output query_seen,
		input ready);
	modport sink(input valid, input status, input reply_len, input query_seen,
		output ready);
endinterface

// ===== sv/scpi_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module scpi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ===== sv/scpi_ctrl.sv =====
// Controller: sequences request intake, the identify compare and result hand-off.
module scpi_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	input  scpi_pkg::dp_stat_t   stat,
	output scpi_pkg::ctrl_cmd_t  cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_PUSH = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       rsp_valid_q;

	assign req_ready    = (state_q == S_IDLE);
	assign rsp_valid    = rsp_valid_q;
	assign cmd.take     = req_valid && req_ready;
	assign cmd.exec_run = (state_q == S_EXEC);
	// The result moves to the output register once that register is free or emptying.
	assign cmd.push     = (state_q == S_PUSH) && (!rsp_valid_q || rsp_ready);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd.take) begin
					state_d = stat.exec_req ? S_EXEC : S_PUSH;
				end
			end
			S_EXEC: begin
				if (stat.cmp_done) begin
					state_d = S_PUSH;
				end
			end
			S_PUSH: begin
				if (cmd.push) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.push) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |=> rsp_valid_q)
		else $error("result transfer did not fill the output register");

	a_exec_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC && stat.cmp_done) |=> state_q == S_PUSH)
		else $error("identify compare did not hand over its result");

endmodule

// ===== sv/scpi_dp.sv =====
// Datapath: parser state, counts, marks, command store and the identify compare.
module scpi_dp #(
	parameter int BUF_DEPTH = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  scpi_pkg::action_t     action,
	input  logic [7:0]            rx_byte,
	input  scpi_pkg::ctrl_cmd_t   cmd,
	output scpi_pkg::dp_stat_t    stat,
	output scpi_pkg::status_t     status,
	output scpi_pkg::reply_len_t  reply_len,
	output logic                  query_seen
);

	localparam int CW = $clog2(BUF_DEPTH);

	localparam logic [1:0] PS_IDLE  = 2'd0;
	localparam logic [1:0] PS_CMD   = 2'd1;
	localparam logic [1:0] PS_PARAM = 2'd2;

	logic [1:0]           pstate_q, pstate_d;
	logic [CW-1:0]        cmd_cnt_q, cmd_cnt_d;
	logic [CW-1:0]        par_cnt_q, par_cnt_d;
	logic                 ready_q, ready_d;
	logic                 query_q, query_d;
	scpi_pkg::status_t    status_d;
	logic                 wr_en;
	logic [CW-1:0]        wr_addr;
	logic [7:0]           rd_data;

	scpi_pkg::idn_idx_t   idx_q;
	logic                 match_q;
	logic                 cand_q;
	logic                 not_ready_q;
	logic                 match_now;

	scpi_pkg::status_t    res_status_q;
	scpi_pkg::reply_len_t res_len_q;
	logic                 res_query_q;
	scpi_pkg::status_t    out_status_q;
	scpi_pkg::reply_len_t out_len_q;
	logic                 out_query_q;

	always_comb begin
		pstate_d  = pstate_q;
		cmd_cnt_d = cmd_cnt_q;
		par_cnt_d = par_cnt_q;
		ready_d   = ready_q;
		query_d   = query_q;
		status_d  = scpi_pkg::STAT_IDLE;
		wr_en     = 1'b0;
		wr_addr   = cmd_cnt_q;
		case (action)
			scpi_pkg::ACT_PARSE: begin
				if (ready_q) begin
					pstate_d = PS_IDLE;
					status_d = scpi_pkg::STAT_ERROR;
				end else if (rx_byte == scpi_pkg::CH_LF) begin
					pstate_d = PS_IDLE;
					if (cmd_cnt_q != '0) begin
						ready_d  = 1'b1;
						status_d = scpi_pkg::STAT_READY;
					end
				end else if (cmd_cnt_q >= CW'(BUF_DEPTH - 1) ||
						par_cnt_q >= CW'(BUF_DEPTH - 1)) begin
					// A full store drops the whole line.
					cmd_cnt_d = '0;
					par_cnt_d = '0;
					ready_d   = 1'b0;
					query_d   = 1'b0;
					pstate_d  = PS_IDLE;
					status_d  = scpi_pkg::STAT_ERROR;
				end else begin
					case (pstate_q)
						PS_IDLE: begin
							if (rx_byte == scpi_pkg::CH_COLON ||
									rx_byte == scpi_pkg::CH_STAR) begin
								wr_en     = 1'b1;
								wr_addr   = '0;
								cmd_cnt_d = CW'(1);
								pstate_d  = PS_CMD;
							end else begin
								cmd_cnt_d = '0;
								par_cnt_d = '0;
								ready_d   = 1'b0;
								query_d   = 1'b0;
							end
						end
						PS_CMD: begin
							if (rx_byte == scpi_pkg::CH_SPACE) begin
								pstate_d = PS_PARAM;
							end else if (rx_byte != scpi_pkg::CH_CR) begin
								wr_en     = 1'b1;
								cmd_cnt_d = cmd_cnt_q + CW'(1);
								if (rx_byte == scpi_pkg::CH_QUERY) begin
									query_d = 1'b1;
								end
							end
						end
						PS_PARAM: begin
							// Parameter text is only counted; nothing reads it back.
							if (rx_byte != scpi_pkg::CH_CR) begin
								par_cnt_d = par_cnt_q + CW'(1);
							end
						end
						default: pstate_d = PS_IDLE;
					endcase
				end
			end
			scpi_pkg::ACT_EXEC, scpi_pkg::ACT_DISCARD: begin
				cmd_cnt_d = '0;
				par_cnt_d = '0;
				ready_d   = 1'b0;
				query_d   = 1'b0;
			end
			default: ;
		endcase
	end

	scpi_ram #(
		.WIDTH(8),
		.DEPTH(BUF_DEPTH)
	) u_cmd_ram (
		.clk     (clk),
		.wr_en   (cmd.take && wr_en),
		.wr_addr (wr_addr),
		.wr_data (rx_byte),
		.rd_addr (CW'(idx_q)),
		.rd_data (rd_data)
	);

	// Read data is registered, so index k checks the stored character at index k-1.
	assign match_now = match_q &&
		(idx_q == '0 || rd_data == scpi_pkg::idn_char(idx_q - 3'd1));

	assign stat.exec_req = (action == scpi_pkg::ACT_EXEC);
	assign stat.cmp_done = (idx_q == scpi_pkg::idn_idx_t'(scpi_pkg::IDN_CHARS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pstate_q  <= PS_IDLE;
			cmd_cnt_q <= '0;
			par_cnt_q <= '0;
			ready_q   <= 1'b0;
			query_q   <= 1'b0;
			idx_q     <= '0;
		end else begin
			if (cmd.take) begin
				pstate_q  <= pstate_d;
				cmd_cnt_q <= cmd_cnt_d;
				par_cnt_q <= par_cnt_d;
				ready_q   <= ready_d;
				query_q   <= query_d;
				idx_q     <= '0;
			end else if (cmd.exec_run && !stat.cmp_done) begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			match_q      <= 1'b1;
			cand_q       <= ready_q && (cmd_cnt_q == CW'(scpi_pkg::IDN_CHARS));
			not_ready_q  <= !ready_q;
			res_status_q <= status_d;
			res_len_q    <= scpi_pkg::LEN_ZERO;
			res_query_q  <= query_d;
		end else if (cmd.exec_run) begin
			match_q <= match_now;
			if (stat.cmp_done) begin
				if (not_ready_q) begin
					res_len_q <= scpi_pkg::LEN_NOT_READY;
				end else if (cand_q && match_now) begin
					res_len_q <= scpi_pkg::LEN_IDN;
				end else begin
					res_len_q <= scpi_pkg::LEN_ZERO;
				end
			end
		end
		if (cmd.push) begin
			out_status_q <= res_status_q;
			out_len_q    <= res_len_q;
			out_query_q  <= res_query_q;
		end
	end

	assign status     = out_status_q;
	assign reply_len  = out_len_q;
	assign query_seen = out_query_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_cnt_q <= CW'(BUF_DEPTH - 1) && par_cnt_q <= CW'(BUF_DEPTH - 1))
		else $error("store count ran past the buffer");

	a_mark_needs_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(ready_q || query_q) |-> cmd_cnt_q != '0)
		else $error("ready or query mark set with an empty command");

endmodule

// ===== sv/scpi_line_command_parser.sv =====
// Top level of the SCPI command line parser.
// Each request is a received byte to parse, an execute or a discard, and each gives exactly
// one result. A parse, discard or unused request goes from intake straight to the result
// hand-off; an execute first runs the identify compare, which reads the five stored command
// characters one a cycle through the single read port of the command RAM.
// A new request is taken while the previous result still waits in the output register.
// The command RAM has no reset; only characters written since the last clear affect a result.
module scpi_line_command_parser #(
	parameter int BUF_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	scpi_req_if.sink    req,
	scpi_rsp_if.source  rsp
);

	scpi_pkg::ctrl_cmd_t cmd;
	scpi_pkg::dp_stat_t  stat;

	scpi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	scpi_dp #(
		.BUF_DEPTH(BUF_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.action     (req.action),
		.rx_byte    (req.rx_byte),
		.cmd        (cmd),
		.stat       (stat),
		.status     (rsp.status),
		.reply_len  (rsp.reply_len),
		.query_seen (rsp.query_seen)
	);

endmodule

// ===== verif/scpi_line_command_parser_test.sv =====
// Self-checking testbench for the SCPI command line parser: directed table, then random lines.
module scpi_line_command_parser_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 64;
	localparam int RANDOM_ITEMS = 700;
	localparam int STALL_LIMIT = 1000;
	localparam int DRAIN_CYCLES = 20;
	localparam int N_DIRECTED = 29;
	localparam scpi_pkg::action_t ACT_UNUSED = 2'd3;
	localparam logic [39:0] IDN_TEXT = "*IDN?";

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_CMD   = 2'd1,
		PH_PARAM = 2'd2
	} line_phase_t;

	typedef struct packed {
		scpi_pkg::status_t    status;
		scpi_pkg::reply_len_t reply_len;
		logic                 query_seen;
	} line_result_t;

	typedef struct packed {
		scpi_pkg::action_t    act;
		logic [7:0]           ch;
		logic [7:0]           reps;
		logic                 typed;
		scpi_pkg::status_t    w_status;
		scpi_pkg::reply_len_t w_len;
		logic                 w_query;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;

	scpi_req_if req();
	scpi_rsp_if rsp();

	scpi_line_command_parser #(.BUF_DEPTH(DEPTH)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow of the parser state.
	line_phase_t line_phase;
	logic [7:0]  cmd_chars [DEPTH];
	int unsigned cmd_len;
	int unsigned param_len;
	logic        line_ready;
	logic        line_query;

	line_result_t pending_replies [$];
	int failures = 0;
	int sent = 0;
	int replies_seen = 0;
	int idn_matches = 0;
	int parse_errors = 0;
	int stall_cycles = 0;
	bit no_gaps = 1'b0;

	stim_row_t directed_rows [N_DIRECTED] = '{
		'{scpi_pkg::ACT_EXEC, 8'h00, 8'd1, 1'b1,
			scpi_pkg::STAT_IDLE, scpi_pkg::LEN_NOT_READY, 1'b0},
		'{scpi_pkg::ACT_PARSE, 8'h58, 8'd1, 1'b1,
			scpi_pkg::STAT_IDLE, scpi_pkg::LEN_ZERO, 1'b0},
		'{scpi_pkg::ACT_PARSE, scpi_pkg::CH_LF, 8'd1, 1'b1,
			scpi_pkg::STAT_IDLE, scpi_pkg::LEN_ZERO, 1'b0},
		'{scpi_pkg::ACT_PARSE, scpi_pkg::CH_STAR, 8'd1, 1'b0,
			scpi_pkg::STAT_IDLE, scpi_pkg::LEN_ZERO, 1'b0},
		'{scpi_pkg::ACT_PARSE, 8'h49, 8'd1, 1'b0,
			scpi_pkg::STAT_IDLE, scpi_pkg::LEN_ZERO, 1'b0},
		'{scpi_pkg::ACT_PARSE, 8'h44, 8'd1, 1'b0,
			scpi_pkg::STAT_IDLE, scpi_pkg::LEN_ZERO, 1'b0},
		'{scpi_pkg::ACT_PARSE, 8'h4E, 8'd1, 1'b0,
			scpi_pkg::STAT_IDLE, scpi_pkg::LEN_ZERO, 1'b0},
		'{scpi_pkg::ACT_PARSE, scpi_pkg::CH_QUERY, 8'd1, 1'b0,
			scpi_pkg::STAT_IDLE, scpi_pkg::LEN_ZERO, 1'b0},
		'{scpi_pkg::ACT_PARSE, scpi_pkg::CH_CR, 8'd1, 1'b0,
			scpi_pkg::STAT_IDLE, scpi_pkg::LEN_ZERO, 1'b0},
		'{scpi_pkg::ACT_PARSE, scpi_pkg::CH_LF, 8'd1, 1'b1,
			scpi_pkg::STAT_READY, scpi_pkg::LEN_ZERO, 1'b1},
		'{scpi_pkg::ACT_PARSE, 8'h41, 8'd1, 1'b1,
			scpi_pkg::STAT_ERROR, scpi_pkg::LEN_ZERO, 1'b1},
		'{scpi_pkg::ACT_EXEC, 8'h00, 8'd1, 1'b1,
			scpi_pkg::STAT_IDLE, scpi_pkg::LEN_IDN, 1'b0},
		'{scpi_pkg::ACT_PARSE, scpi_pkg::CH_COLON, 8'd1, 1'b0,
			scpi_pkg::STAT_IDLE, scpi_pkg::LEN_ZERO, 1'b0},
		'{scpi_pkg::ACT_PARSE, 8'h00, 8'd1, 1'b0,
			scpi_pkg::STAT_IDLE, scpi_pkg::LEN_ZERO, 1'b0},
		'{scpi_pkg::ACT_PARSE, 8'hFF, 8'd1, 1'b0,
			scpi_pkg::STAT_IDLE, scpi_pkg::LEN_ZERO, 1'b0},
		'{scpi_pkg::ACT_PARSE, scpi_pkg::CH_SPACE, 8'd1, 1'b0,
			scpi_pkg::STAT_IDLE, scpi_pkg::LEN_ZERO, 1'b0},
		'{scpi_pkg::ACT_PARSE, 8'h70, 8'd1, 1'b0,
			scpi_pkg::STAT_IDLE, scpi_pkg::LEN_ZERO, 1'b0},
		'{scpi_pkg::ACT_PARSE, scpi_pkg::CH_LF, 8'd1, 1'b1,
			scpi_pkg::STAT_READY, scpi_pkg::LEN_ZERO, 1'b0},
		'{scpi_pkg::ACT_EXEC, 8'hFF, 8'd1, 1'b1,
			scpi_pkg::STAT_IDLE, scpi_pkg::LEN_ZERO, 1'b0},
		'{scpi_pkg::ACT_PARSE, scpi_pkg::CH_STAR, 8'd1, 1'b0,
			scpi_pkg::STAT_IDLE, scpi_pkg::LEN_ZERO, 1'b0},
		'{scpi_pkg::ACT_DISCARD, 8'h00, 8'd1, 1'b1,
			scpi_pkg::STAT_IDLE, scpi_pkg::LEN_ZERO, 1'b0},
		'{scpi_pkg::ACT_PARSE, 8'h43, 8'd1, 1'b0,
			scpi_pkg::STAT_IDLE, scpi_pkg::LEN_ZERO, 1'b0},
		'{scpi_pkg::ACT_PARSE, scpi_pkg::CH_LF, 8'd1, 1'b1,
			scpi_pkg::STAT_READY, scpi_pkg::LEN_ZERO, 1'b0},
		'{scpi_pkg::ACT_EXEC, 8'h00, 8'd1, 1'b1,
			scpi_pkg::STAT_IDLE, scpi_pkg::LEN_ZERO, 1'b0},
		'{ACT_UNUSED, 8'hFF, 8'd1, 1'b1,
			scpi_pkg::STAT_IDLE, scpi_pkg::LEN_ZERO, 1'b0},
		'{scpi_pkg::ACT_PARSE, scpi_pkg::CH_STAR, 8'd1, 1'b0,
			scpi_pkg::STAT_IDLE, scpi_pkg::LEN_ZERO, 1'b0},
		'{scpi_pkg::ACT_PARSE, 8'h41, 8'd62, 1'b0,
			scpi_pkg::STAT_IDLE, scpi_pkg::LEN_ZERO, 1'b0},
		'{scpi_pkg::ACT_PARSE, 8'h41, 8'd1, 1'b1,
			scpi_pkg::STAT_ERROR, scpi_pkg::LEN_ZERO, 1'b0},
		'{scpi_pkg::ACT_EXEC, 8'h00, 8'd1, 1'b1,
			scpi_pkg::STAT_IDLE, scpi_pkg::LEN_NOT_READY, 1'b0}
	};

	function automatic void clear_line();
		cmd_len = 0;
		param_len = 0;
		line_ready = 1'b0;
		line_query = 1'b0;
	endfunction

	function automatic line_result_t predict_reply(scpi_pkg::action_t act, logic [7:0] ch);
		line_result_t r;
		logic same;
		r = '0;
		case (act)
			scpi_pkg::ACT_PARSE: begin
				if (line_ready) begin
					line_phase = PH_IDLE;
					r.status = scpi_pkg::STAT_ERROR;
				end else if (ch == scpi_pkg::CH_LF) begin
					line_phase = PH_IDLE;
					if (cmd_len > 0) begin
						line_ready = 1'b1;
						r.status = scpi_pkg::STAT_READY;
					end
				end else if (cmd_len >= DEPTH - 1 || param_len >= DEPTH - 1) begin
					clear_line();
					line_phase = PH_IDLE;
					r.status = scpi_pkg::STAT_ERROR;
				end else begin
					case (line_phase)
						PH_IDLE: begin
							if (ch == scpi_pkg::CH_COLON || ch == scpi_pkg::CH_STAR) begin
								cmd_chars[0] = ch;
								cmd_len = 1;
								line_phase = PH_CMD;
							end else begin
								clear_line();
							end
						end
						PH_CMD: begin
							if (ch == scpi_pkg::CH_SPACE) begin
								line_phase = PH_PARAM;
							end else if (ch != scpi_pkg::CH_CR) begin
								cmd_chars[cmd_len % DEPTH] = ch;
								cmd_len++;
								if (ch == scpi_pkg::CH_QUERY)
									line_query = 1'b1;
							end
						end
						PH_PARAM: begin
							if (ch != scpi_pkg::CH_CR)
								param_len++;
						end
						default: line_phase = PH_IDLE;
					endcase
				end
			end
			scpi_pkg::ACT_EXEC: begin
				if (!line_ready) begin
					r.reply_len = scpi_pkg::LEN_NOT_READY;
				end else if (cmd_len == scpi_pkg::IDN_CHARS) begin
					same = 1'b1;
					for (int i = 0; i < scpi_pkg::IDN_CHARS; i++)
						if (cmd_chars[i] != IDN_TEXT[8*(4-i) +: 8])
							same = 1'b0;
					if (same)
						r.reply_len = scpi_pkg::LEN_IDN;
				end
				clear_line();
			end
			scpi_pkg::ACT_DISCARD: clear_line();
			default: ;
		endcase
		r.query_seen = line_query;
		return r;
	endfunction

	// Mostly letters, with some query marks, carriage returns and arbitrary bytes.
	function automatic logic [7:0] line_char();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 70)
			return 8'h41 + 8'($urandom_range(0, 25));
		else if (pick < 78)
			return scpi_pkg::CH_QUERY;
		else if (pick < 86)
			return scpi_pkg::CH_CR;
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic put_request(input scpi_pkg::action_t act, input logic [7:0] ch,
		input bit typed = 1'b0, input line_result_t want = '0);
		line_result_t guess;
		int gap;
		gap = 0;
		if (!no_gaps && $urandom_range(0, 99) < 11)
			gap = $urandom_range(1, 4);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.action <= act;
		req.rx_byte <= ch;
		do @(posedge clk); while (!req.ready);
		guess = predict_reply(act, ch);
		pending_replies.push_back(typed ? want : guess);
		sent++;
	endtask

	always @(posedge clk) begin
		line_result_t want;
		rsp.ready <= no_gaps || ($urandom_range(0, 99) >= 11);
		if (arst_n && rsp.valid && rsp.ready) begin
			replies_seen++;
			if (pending_replies.size() == 0) begin
				$error("result with nothing expected: status %0d reply_len %0d query_seen %0d",
					rsp.status, rsp.reply_len, rsp.query_seen);
				failures++;
			end else begin
				want = pending_replies.pop_front();
				if (want.reply_len == scpi_pkg::LEN_IDN)
					idn_matches++;
				if (want.status == scpi_pkg::STAT_ERROR)
					parse_errors++;
				if (rsp.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp.status);
					failures++;
				end
				if (rsp.reply_len !== want.reply_len) begin
					$error("reply_len: expected %0d, got %0d", want.reply_len, rsp.reply_len);
					failures++;
				end
				if (rsp.query_seen !== want.query_seen) begin
					$error("query_seen: expected %0d, got %0d",
						want.query_seen, rsp.query_seen);
					failures++;
				end
			end
		end
	end

	// Ends the run when neither channel has moved a transfer for too long.
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		int base;
		int pick;
		int body;
		int args;
		bit idn;
		bit paused;
		logic [7:0] lead;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.action = scpi_pkg::ACT_PARSE;
		req.rx_byte = 8'h00;
		line_phase = PH_IDLE;
		foreach (cmd_chars[i])
			cmd_chars[i] = 8'h00;
		clear_line();
		paused = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < N_DIRECTED; r++)
			repeat (directed_rows[r].reps)
				put_request(directed_rows[r].act, directed_rows[r].ch, directed_rows[r].typed,
					{directed_rows[r].w_status, directed_rows[r].w_len,
					directed_rows[r].w_query});

		base = sent;
		while (sent < base + RANDOM_ITEMS) begin
			no_gaps = (sent >= base + 350) && (sent < base + 520);
			// Hold the sender once until the parser has drained every result.
			if (!paused && sent >= base + 420) begin
				paused = 1'b1;
				req.valid <= 1'b0;
				while (pending_replies.size() != 0)
					@(posedge clk);
			end
			pick = $urandom_range(0, 99);
			if (pick < 72) begin
				idn = ($urandom_range(0, 3) == 0);
				lead = (idn || $urandom_range(0, 1)) ? scpi_pkg::CH_STAR : scpi_pkg::CH_COLON;
				put_request(scpi_pkg::ACT_PARSE, lead);
				if (idn) begin
					for (int i = 1; i < scpi_pkg::IDN_CHARS; i++) begin
						put_request(scpi_pkg::ACT_PARSE, IDN_TEXT[8*(4-i) +: 8]);
						if ($urandom_range(0, 9) == 0)
							put_request(scpi_pkg::ACT_PARSE, scpi_pkg::CH_CR);
					end
				end else begin
					body = ($urandom_range(0, 11) == 0) ? $urandom_range(55, 70)
						: $urandom_range(0, 7);
					repeat (body) put_request(scpi_pkg::ACT_PARSE, line_char());
				end
				if ($urandom_range(0, 2) == 0) begin
					put_request(scpi_pkg::ACT_PARSE, scpi_pkg::CH_SPACE);
					args = ($urandom_range(0, 11) == 0) ? $urandom_range(60, 75)
						: $urandom_range(0, 8);
					repeat (args) put_request(scpi_pkg::ACT_PARSE, line_char());
				end
				if ($urandom_range(0, 1))
					put_request(scpi_pkg::ACT_PARSE, scpi_pkg::CH_CR);
				put_request(scpi_pkg::ACT_PARSE, scpi_pkg::CH_LF);
				pick = $urandom_range(0, 99);
				// A stray byte after the newline hits the command while it is ready, unless a full store dropped the line.
				if (pick < 15)
					put_request(scpi_pkg::ACT_PARSE, 8'($urandom_range(0, 255)));
				if (pick < 80)
					put_request(scpi_pkg::ACT_EXEC, 8'($urandom_range(0, 255)));
				else
					put_request(scpi_pkg::ACT_DISCARD, 8'($urandom_range(0, 255)));
			end else begin
				repeat ($urandom_range(1, 6))
					put_request(scpi_pkg::action_t'($urandom_range(0, 3)),
						8'($urandom_range(0, 255)));
			end
		end
		no_gaps = 1'b0;
		req.valid <= 1'b0;

		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d requests and checked %0d results, with %0d identify matches",
			sent, replies_seen, idn_matches);
		$display("and %0d parser errors; %0d mismatches found.", parse_errors, failures);
		if (failures == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
